/* design/ebsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ebsc_pkg
// Shared types and constants for the encoder and button command transmitter.
// ----------------------------------------------------------------------------
package ebsc_pkg;

    localparam int BIT_TICKS_W     = 16;
    localparam int BIT_TICKS_RESET = 100;
    localparam int CODE_W          = 3;
    localparam int BIT_IDX_W       = 2;
    localparam int DATA_BITS       = 4;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 8;

    // Command codes carried in the four data bits of a frame
    localparam logic [CODE_W-1:0] CMD_INC = 3'd0;
    localparam logic [CODE_W-1:0] CMD_DEC = 3'd1;
    localparam logic [CODE_W-1:0] CMD_EXP = 3'd2;
    localparam logic [CODE_W-1:0] CMD_OK  = 3'd3;
    localparam logic [CODE_W-1:0] CMD_SW  = 3'd4;

    // Button bit order in the pending and last-level vectors
    localparam int BTN_EXP = 0;
    localparam int BTN_OK  = 1;
    localparam int BTN_SW  = 2;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_START   = 5'b00010,
        PH_DATA    = 5'b00100,
        PH_GAP_ENC = 5'b01000,
        PH_GAP_BTN = 5'b10000
    } t_phase;

    // Highest pending button, exp first; only meaningful when any bit is set
    function automatic logic [CODE_W-1:0] pick_button(input logic [2:0] pend);
        logic [CODE_W-1:0] code;
        if (pend[BTN_EXP]) begin
            code = CMD_EXP;
        end else if (pend[BTN_OK]) begin
            code = CMD_OK;
        end else begin
            code = CMD_SW;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

/* design/encoder_buttons_to_serial_commands_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_buttons_to_serial_commands_unit
// Turns sampled encoder and button levels into serial command frames.
// ----------------------------------------------------------------------------
// Each input transaction is one sampling tick of five pin levels; each tick
// yields exactly one output transaction carrying the transmit line level and
// a busy flag as they stand after that tick. One tick is taken every clock
// cycle unless a result is left waiting: the whole update is a single pass
// of logic from the state registers into the result register, and a result
// appears in the cycle after its tick. A new tick is let in while the result
// register is empty or in the same cycle that its result is taken downstream;
// a result left waiting holds the input off. A falling edge on encoder A
// while idle sends INC (B high) or DEC (B low); falling button edges latch a
// pending flag (only the highest of exp, ok, sw on one tick) that is sent as
// EXP, OK or SW once the line is free. A frame is a low start bit and four
// data bits, LSB first, each held for bit_ticks ticks (zero acts as one),
// then one high gap tick. Write bit_ticks only while no tick is in flight.
// ----------------------------------------------------------------------------
module encoder_buttons_to_serial_commands_unit
    import ebsc_pkg::*;
#(
    parameter int unsigned P_BIT_TICKS_RESET = BIT_TICKS_RESET
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tdata: [0] enc_a, [1] enc_b, [2] btn_exp, [3] btn_ok, [4] btn_sw
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tdata: [0] tx_line, [1] tx_busy
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [BIT_TICKS_W-1:0] i_cfg_wdata
);

    logic [BIT_TICKS_W-1:0] r_bit_ticks;
    logic                   r_enc_a_last, n_enc_a_last;
    logic [2:0]             r_button_last, n_button_last;
    logic [2:0]             r_pending, n_pending;
    logic [CODE_W-1:0]      r_frame, n_frame;
    logic [BIT_IDX_W-1:0]   r_bit_idx, n_bit_idx;
    logic [BIT_TICKS_W-1:0] r_tick, n_tick;
    t_phase                 r_phase, n_phase;
    logic                   r_out_valid;
    logic                   r_out_line, n_out_line;
    logic                   r_out_busy, n_out_busy;

    logic                   accept;
    logic [BIT_TICKS_W-1:0] bt;
    logic                   in_a, in_b;
    logic [2:0]             in_btn, fall, pend_set;
    logic                   bit_done;
    logic [DATA_BITS-1:0]   frame_bits;

    assign in_a   = i_s_axis_tdata[0];
    assign in_b   = i_s_axis_tdata[1];
    assign in_btn = i_s_axis_tdata[4:2];

    // Take a tick whenever the result register is empty or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign bt       = (r_bit_ticks == '0) ? BIT_TICKS_W'(1) : r_bit_ticks;
    assign bit_done = (r_tick >= bt);
    assign fall     = r_button_last & ~in_btn;

    // Latch only the highest falling button of this tick
    always_comb begin
        pend_set = r_pending;
        if (fall[BTN_EXP]) begin
            pend_set[BTN_EXP] = 1'b1;
        end else if (fall[BTN_OK]) begin
            pend_set[BTN_OK] = 1'b1;
        end else if (fall[BTN_SW]) begin
            pend_set[BTN_SW] = 1'b1;
        end
    end

    always_comb begin
        n_enc_a_last  = r_enc_a_last;
        n_button_last = in_btn;
        n_pending     = pend_set;
        n_frame       = r_frame;
        n_bit_idx     = r_bit_idx;
        n_tick        = r_tick;
        n_phase       = r_phase;

        unique case (r_phase)
            PH_START: begin
                if (bit_done) begin
                    n_phase   = PH_DATA;
                    n_bit_idx = '0;
                    n_tick    = BIT_TICKS_W'(1);
                end else begin
                    n_tick = r_tick + BIT_TICKS_W'(1);
                end
            end
            PH_DATA: begin
                if (bit_done) begin
                    if (r_bit_idx == BIT_IDX_W'(DATA_BITS - 1)) begin
                        // Clear the flag of the button whose frame just ended
                        case (r_frame)
                            CMD_EXP: n_pending[BTN_EXP] = 1'b0;
                            CMD_OK:  n_pending[BTN_OK]  = 1'b0;
                            CMD_SW:  n_pending[BTN_SW]  = 1'b0;
                            default: ;
                        endcase
                        n_phase   = (r_frame == CMD_INC || r_frame == CMD_DEC)
                                    ? PH_GAP_ENC : PH_GAP_BTN;
                        n_tick    = '0;
                        n_bit_idx = '0;
                    end else begin
                        n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
                        n_tick    = BIT_TICKS_W'(1);
                    end
                end else begin
                    n_tick = r_tick + BIT_TICKS_W'(1);
                end
            end
            PH_GAP_ENC: begin
                // A pending button follows an encoder frame straight away
                if (|pend_set) begin
                    n_frame   = pick_button(pend_set);
                    n_bit_idx = '0;
                    n_tick    = BIT_TICKS_W'(1);
                    n_phase   = PH_START;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_GAP_BTN: begin
                n_phase = PH_IDLE;
            end
            default: begin
                // Idle: sample encoder A, the encoder wins over buttons
                n_enc_a_last = in_a;
                if (!in_a && r_enc_a_last) begin
                    n_frame   = in_b ? CMD_INC : CMD_DEC;
                    n_bit_idx = '0;
                    n_tick    = BIT_TICKS_W'(1);
                    n_phase   = PH_START;
                end else if (|pend_set) begin
                    n_frame   = pick_button(pend_set);
                    n_bit_idx = '0;
                    n_tick    = BIT_TICKS_W'(1);
                    n_phase   = PH_START;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Line level from the state after this tick
    assign frame_bits = {1'b0, n_frame};

    always_comb begin
        n_out_line = 1'b1;
        n_out_busy = 1'b1;
        unique case (n_phase)
            PH_START:   n_out_line = 1'b0;
            PH_DATA:    n_out_line = frame_bits[n_bit_idx];
            PH_GAP_ENC: n_out_line = 1'b1;
            PH_GAP_BTN: n_out_line = 1'b1;
            default:    n_out_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks <= BIT_TICKS_W'(P_BIT_TICKS_RESET);
        end else if (i_cfg_we) begin
            r_bit_ticks <= i_cfg_wdata;
        end
    end

    // Advance the state on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_a_last  <= 1'b0;
            r_button_last <= 3'b111;
            r_pending     <= '0;
            r_frame       <= '0;
            r_bit_idx     <= '0;
            r_tick        <= '0;
            r_phase       <= PH_IDLE;
        end else if (accept) begin
            r_enc_a_last  <= n_enc_a_last;
            r_button_last <= n_button_last;
            r_pending     <= n_pending;
            r_frame       <= n_frame;
            r_bit_idx     <= n_bit_idx;
            r_tick        <= n_tick;
            r_phase       <= n_phase;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_line <= n_out_line;
            r_out_busy <= n_out_busy;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, r_out_busy, r_out_line};

    // The held result always describes the current state
    a_busy_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_busy == (r_phase != PH_IDLE)))
        else $error("busy flag disagrees with transmitter phase");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_busy) |-> r_out_line)
        else $error("line low while idle");

    a_start_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_phase == PH_START) |-> !r_out_line)
        else $error("line high during start bit");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START || r_phase == PH_DATA) |-> (r_tick != '0))
        else $error("bit tick counter zero inside a bit");

    a_state_frozen_without_accept: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (!accept && !i_cfg_we) |=> ($stable(r_phase) && $stable(r_pending)))
        else $error("state moved without an accepted tick");

endmodule
`default_nettype wire

/* dv/encoder_buttons_to_serial_commands_unit_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_buttons_to_serial_commands_unit_test
// Self-checking bench for the encoder and button command transmitter.
// ----------------------------------------------------------------------------
// Feed pin-level ticks into the slave stream and predict the transmit line
// and busy flag for every tick. Compare each output transaction with the
// oldest prediction. Run a directed opening at the reset bit time and zero,
// then random phases over several bit times (one, small values, maximum).
// Vary the sender gaps and the receiver back-pressure from phase to phase.
// ----------------------------------------------------------------------------
module encoder_buttons_to_serial_commands_unit_test;
    import ebsc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic busy;
        logic line;
    } t_tx_level;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the transmitter state and queues one predicted
    // line level per accepted tick.
    // ------------------------------------------------------------------------
    class tx_line_scoreboard;
        logic [BIT_TICKS_W-1:0] bit_ticks;
        logic                   enc_a_prev;
        logic [2:0]             btn_prev;
        logic [2:0]             btn_waiting;
        logic [3:0]             cmd_code;
        int unsigned            data_bit;
        int unsigned            held;
        t_phase                 phase;
        t_tx_level              level_q[$];
        bit                     failed;

        function new();
            bit_ticks   = BIT_TICKS_W'(BIT_TICKS_RESET);
            enc_a_prev  = 1'b0;
            btn_prev    = 3'b111;
            btn_waiting = 3'b000;
            cmd_code    = 4'd0;
            data_bit    = 0;
            held        = 0;
            phase       = PH_IDLE;
            failed      = 1'b0;
        endfunction

        function void set_bit_ticks(input logic [BIT_TICKS_W-1:0] value);
            bit_ticks = value;
        endfunction

        function int waiting();
            return level_q.size();
        endfunction

        function void begin_frame(input logic [CODE_W-1:0] code);
            cmd_code = {1'b0, code};
            data_bit = 0;
            held     = 1;
            phase    = PH_START;
        endfunction

        // Highest waiting button: exp, then ok, then sw
        function logic [CODE_W-1:0] button_cmd();
            if (btn_waiting[BTN_EXP]) begin
                return CMD_EXP;
            end
            if (btn_waiting[BTN_OK]) begin
                return CMD_OK;
            end
            return CMD_SW;
        endfunction

        // pins: [0] enc_a, [1] enc_b, [2] btn_exp, [3] btn_ok, [4] btn_sw
        function void note_tick(input logic [4:0] pins);
            logic [2:0]  cur;
            logic [2:0]  fall;
            int unsigned span;
            t_tx_level   lvl;
            cur  = pins[4:2];
            fall = btn_prev & ~cur;
            span = (bit_ticks == 0) ? 1 : int'(bit_ticks);

            // Only the highest of simultaneous presses is latched
            if (fall[BTN_EXP]) begin
                btn_waiting[BTN_EXP] = 1'b1;
            end else if (fall[BTN_OK]) begin
                btn_waiting[BTN_OK] = 1'b1;
            end else if (fall[BTN_SW]) begin
                btn_waiting[BTN_SW] = 1'b1;
            end
            btn_prev = cur;

            case (phase)
                PH_START: begin
                    if (held >= span) begin
                        phase    = PH_DATA;
                        data_bit = 0;
                        held     = 1;
                    end else begin
                        held++;
                    end
                end
                PH_DATA: begin
                    if (held >= span) begin
                        if (data_bit >= 3) begin
                            // Clear the sent button only once its frame ends
                            if (cmd_code >= 4'(CMD_EXP) && cmd_code <= 4'(CMD_SW)) begin
                                btn_waiting[cmd_code - 4'(CMD_EXP)] = 1'b0;
                            end
                            phase    = (cmd_code < 4'(CMD_EXP)) ? PH_GAP_ENC : PH_GAP_BTN;
                            held     = 0;
                            data_bit = 0;
                        end else begin
                            data_bit++;
                            held = 1;
                        end
                    end else begin
                        held++;
                    end
                end
                PH_GAP_ENC: begin
                    if (btn_waiting != 3'b000) begin
                        begin_frame(button_cmd());
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_GAP_BTN: begin
                    phase = PH_IDLE;
                end
                default: begin
                    // Encoder is sampled and remembered only when idle
                    if (!pins[0] && enc_a_prev) begin
                        enc_a_prev = pins[0];
                        begin_frame(pins[1] ? CMD_INC : CMD_DEC);
                    end else begin
                        enc_a_prev = pins[0];
                        if (btn_waiting != 3'b000) begin
                            begin_frame(button_cmd());
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                end
            endcase

            case (phase)
                PH_START:   lvl = '{busy: 1'b1, line: 1'b0};
                PH_DATA:    lvl = '{busy: 1'b1, line: cmd_code[data_bit[1:0]]};
                PH_GAP_ENC,
                PH_GAP_BTN: lvl = '{busy: 1'b1, line: 1'b1};
                default:    lvl = '{busy: 1'b0, line: 1'b1};
            endcase
            level_q.push_back(lvl);
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
            t_tx_level want;
            if (level_q.size() == 0) begin
                $display("%0t: output transaction with nothing expected, actual %0h",
                         $time, tdata);
                failed = 1'b1;
                return;
            end
            want = level_q.pop_front();
            if (tdata[0] !== want.line) begin
                $display("%0t: tx_line expected %0b actual %0b", $time, want.line, tdata[0]);
                failed = 1'b1;
            end
            if (tdata[1] !== want.busy) begin
                $display("%0t: tx_busy expected %0b actual %0b", $time, want.busy, tdata[1]);
                failed = 1'b1;
            end
            if (tdata[OUT_TDATA_W-1:2] !== '0) begin
                $display("%0t: tdata padding expected 0 actual %0h", $time,
                         tdata[OUT_TDATA_W-1:2]);
                failed = 1'b1;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [0] enc_a, [1] enc_b, [2] btn_exp,
                                              // [3] btn_ok, [4] btn_sw
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [0] tx_line, [1] tx_busy
    logic                   i_cfg_we;
    logic [BIT_TICKS_W-1:0] i_cfg_wdata;

    tx_line_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                cycles;
    logic [4:0]        pin_state;

    encoder_buttons_to_serial_commands_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("encoder_buttons_to_serial_commands_unit: mismatch");
            $finish;
        end
    end

    // Receiver: check each output transaction, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Pack the five pin levels in tdata order
    function automatic logic [4:0] pin_word(input logic a, input logic b, input logic exp,
                                            input logic ok, input logic sw);
        return {sw, ok, exp, b, a};
    endfunction

    // Offer one tick, with a random gap first, and hold it until taken
    task automatic send_tick(input logic [4:0] pins);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-5){1'b0}}, pins};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_tick(pins);
    endtask

    // Stop sending and wait for every predicted transaction to arrive
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.waiting() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_bit_ticks(input logic [BIT_TICKS_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_bit_ticks(value);
        i_cfg_we    <= 1'b0;
    endtask

    // Advance the pins: mostly encoder steps and sticky button presses,
    // with the odd tick of pure noise
    task automatic step_pins();
        if ($urandom_range(9) == 0) begin
            pin_state = 5'($urandom_range(31));
        end else begin
            if ($urandom_range(2) == 0) begin
                pin_state[0] = ~pin_state[0];
            end
            pin_state[1] = 1'($urandom_range(1));
            for (int k = 2; k < 5; k++) begin
                if ($urandom_range(7) == 0) begin
                    pin_state[k] = ~pin_state[k];
                end
            end
        end
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input logic [BIT_TICKS_W-1:0] ticks, input bit hold_off);
        write_bit_ticks(ticks);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            // Let the block run dry once mid-phase
            if (hold_off && n == count / 2) begin
                drain();
            end
            step_pins();
            send_tick(pin_state);
        end
    endtask

    initial begin
        sb              = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        pin_state       = 5'b11111;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset bit time: the whole start bit of an INC frame and part of its
        // first data bit, with an exp press riding along
        send_tick(pin_word(1, 1, 1, 1, 1));
        send_tick(pin_word(0, 1, 1, 1, 1));
        for (int n = 0; n < 110; n++) begin
            send_tick(pin_word(0, 1, (n != 60), 1, 1));
        end

        // Directed: bit time zero acts as one
        write_bit_ticks('0);
        // Finish the INC frame and the exp frame behind it, then sit idle
        for (int n = 0; n < 16; n++) begin
            send_tick(pin_word(0, 1, 1, 1, 1));
        end
        send_tick(pin_word(1, 1, 1, 1, 1));   // encoder high, all released
        send_tick(pin_word(0, 1, 1, 1, 1));   // fall with B high: INC
        send_tick(pin_word(1, 1, 1, 1, 1));   // encoder ignored mid-frame
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 0, 0, 0));   // all three at once: exp only
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(1, 0, 1, 0, 1));   // ok press waits behind exp
        send_tick(pin_word(1, 0, 1, 1, 1));   // gap: exp follows at once
        send_tick(pin_word(1, 0, 0, 1, 1));   // exp again while its flag is still pending: no new frame
        send_tick(pin_word(1, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 0));   // sw press, encoder fall ignored
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(1, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(1, 1, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));   // fall with B low, ignored mid-frame
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));
        send_tick(pin_word(0, 0, 1, 1, 1));

        // Random phases over bit times and handshake pressure
        run_random(80, 0, 0, 16'd1, 1'b0);
        run_random(70, 88, 0, 16'd2, 1'b1);
        run_random(70, 0, 88, 16'd3, 1'b0);
        run_random(70, 37, 37, 16'd1, 1'b0);
        // Longest bit time: any start bit holds low through the whole phase
        run_random(40, 0, 0, 16'hFFFF, 1'b0);
        run_random(60, 37, 37, 16'd4, 1'b0);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (!sb.failed && sb.waiting() == 0) begin
            $display("encoder_buttons_to_serial_commands_unit: match");
        end else begin
            $display("encoder_buttons_to_serial_commands_unit: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
